/* hdl/sdq_pkg.sv */
package sdq_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_POP_MIN = 2'd1,
        OP_POP_MAX = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

/* hdl/sorted_double_ended_queue_unit.sv */
// Sorted double-ended queue: holds up to CAPACITY signed 32-bit values in
// ascending order and serves one request at a time.
// Input channel (s_valid/s_ready, s_op, s_value): insert s_value, pop the
// smallest value or pop the largest value. Result channel (m_valid/m_ready):
// the inserted or removed value, a status (ok, empty on pop, full on insert)
// and the number of values held after the request.
// The values live in a single-port-write, single-port-read memory used as a
// ring; a head pointer makes pop-smallest a pointer bump, so only insert
// walks the store. One signed comparator handles the walk: each cycle it
// checks one entry against the new value and moves it up one slot if larger.
// A full or empty request or the unused op code goes from the start step
// straight to the finish step; a pop reads its entry first; an insert moves
// each larger entry up, compares once more when the walk stops on an entry
// not above the value, then places it. s_ready is high only while idle, so a
// new request is taken in the cycle after the previous result is loaded.
// The result register parts the two sides: when the receiver stalls, the
// result waits in it and the next request is still accepted and processed;
// that request then waits in its final step until the register is free.
// Reset (aresetn low at a clock edge) empties the store at once; no clearing
// pass is needed since only entries below the fill count are ever read.
module sorted_double_ended_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [sdq_pkg::OP_W-1:0]               s_op,
    input  logic signed [sdq_pkg::VALUE_W-1:0]     s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [sdq_pkg::VALUE_W-1:0]     m_result_value,
    output logic [sdq_pkg::STAT_W-1:0]             m_status,
    output logic [sdq_pkg::COUNT_W-1:0]            m_entry_count
);
    import sdq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_EXT = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SHIFT_CMP,
        S_PLACE,
        S_POP_RD,
        S_FINISH
    } state_t;

    // Map a logical slot (0 = smallest) to its ring address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] lidx);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, lidx};
        if (sum >= CAP_EXT) begin
            sum = sum - CAP_EXT;
        end
        return sum[AW-1:0];
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    status_t stat_reg, stat_next;

    logic m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0] m_result_value_reg, m_result_value_next;
    status_t m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_entry_count_reg, m_entry_count_next;

    // Ring storage
    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic signed [VALUE_W-1:0] mem_wdata;

    logic [AW-1:0] count_lo;
    logic [AW-1:0] count_m1;
    logic [CW+COUNT_W-1:0] count_ext;
    logic [AW:0] head_inc;

    assign count_lo  = count_reg[AW-1:0];
    assign count_m1  = count_lo - AW'(1);
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};
    assign head_inc  = {1'b0, head_reg} + (AW + 1)'(1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next          = state_reg;
        op_next             = op_reg;
        val_next            = val_reg;
        head_next           = head_reg;
        count_next          = count_reg;
        pos_next            = pos_reg;
        res_next            = res_reg;
        stat_next           = stat_reg;
        m_valid_next        = m_valid_reg;
        m_result_value_next = m_result_value_reg;
        m_status_next       = m_status_reg;
        m_entry_count_next  = m_entry_count_reg;
        mem_we              = 1'b0;
        mem_waddr           = phys(head_reg, pos_reg);
        mem_wdata           = val_reg;
        mem_raddr           = '0;

        // Drop the result once the receiver takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = op_t'(s_op);
                    val_next   = s_value;
                    state_next = S_START;
                end
            end
            S_START: begin
                res_next  = '0;
                stat_next = ST_OK;
                case (op_reg)
                    OP_INSERT: begin
                        pos_next = count_lo;
                        if (count_reg >= CAP_CNT) begin
                            stat_next  = ST_FULL;
                            state_next = S_FINISH;
                        end else if (count_reg == '0) begin
                            state_next = S_PLACE;
                        end else begin
                            mem_raddr  = phys(head_reg, count_m1);
                            state_next = S_SHIFT_CMP;
                        end
                    end
                    OP_POP_MIN: begin
                        if (count_reg == '0) begin
                            stat_next  = ST_EMPTY;
                            state_next = S_FINISH;
                        end else begin
                            mem_raddr  = head_reg;
                            head_next  = (head_inc >= CAP_EXT) ? '0 : head_inc[AW-1:0];
                            count_next = count_reg - CW'(1);
                            state_next = S_POP_RD;
                        end
                    end
                    OP_POP_MAX: begin
                        if (count_reg == '0) begin
                            stat_next  = ST_EMPTY;
                            state_next = S_FINISH;
                        end else begin
                            mem_raddr  = phys(head_reg, count_m1);
                            count_next = count_reg - CW'(1);
                            state_next = S_POP_RD;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SHIFT_CMP: begin
                // Move a larger entry up one slot and look at the next one down.
                if (rd_data_reg > val_reg) begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg;
                    pos_next  = pos_reg - AW'(1);
                    if (pos_reg == AW'(1)) begin
                        state_next = S_PLACE;
                    end else begin
                        mem_raddr = phys(head_reg, pos_reg - AW'(2));
                    end
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
                res_next   = val_reg;
                stat_next  = ST_OK;
                state_next = S_FINISH;
            end
            S_POP_RD: begin
                res_next   = rd_data_reg;
                stat_next  = ST_OK;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the result register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_result_value_next = res_reg;
                    m_status_next       = stat_reg;
                    m_entry_count_next  = count_ext[COUNT_W-1:0];
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg             <= op_next;
        val_reg            <= val_next;
        pos_reg            <= pos_next;
        res_reg            <= res_next;
        stat_reg           <= stat_next;
        m_result_value_reg <= m_result_value_next;
        m_status_reg       <= m_status_next;
        m_entry_count_reg  <= m_entry_count_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_status       = m_status_reg;
    assign m_entry_count  = m_entry_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("fill count above capacity");

    a_walk_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT_CMP |-> pos_reg != '0)
        else $error("insert walk below slot zero");

    a_place_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PLACE |-> count_reg < CAP_CNT)
        else $error("insert placed into a full store");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> m_result_value_reg == '0)
        else $error("failed request carries a nonzero value");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_START)
        else $error("accepted request did not start");

endmodule
